// ===== rtl/wrr_pkg.sv =====
// Package: shared types and constants for the weighted round-robin unit picker.
`timescale 1ns / 1ps
`default_nettype none
package wrr_pkg;
	localparam int MAX_UNITS_DEF      = 16;
	localparam int USE_COUNT_BITS_DEF = 16;
	localparam int TIME_W             = 32;
	localparam int MGR_W              = 8;
	localparam int SLOT_W             = 4;
	localparam int STATUS_W           = 3;

	localparam logic CMD_REGISTER = 1'b0;
	localparam logic CMD_PICK     = 1'b1;

	localparam logic [STATUS_W-1:0] ST_GRANTED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NONE        = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REGISTERED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;

	// Request from sequencer to the multiply-compare unit
	typedef struct packed {
		logic        start;
		logic [31:0] uses;
		logic [31:0] tval;
		logic [31:0] limit;
	} mul_req_t;

	// Response from the multiply-compare unit
	typedef struct packed {
		logic done;
		logic ge;
	} mul_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/wrr_mulcmp.sv =====
// Shared unit: decides uses * time >= limit with two 32x16 partial products.
`timescale 1ns / 1ps
`default_nettype none
module wrr_mulcmp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire wrr_pkg::mul_req_t req,
	output wrr_pkg::mul_rsp_t     rsp
);
	typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_DONE} mstate_t;
	mstate_t     state_q;
	logic [31:0] uses_q, tval_q, limit_q;
	logic [63:0] acc_q;
	logic [47:0] pp;

	// One 32x16 partial product per cycle
	assign pp = (state_q == M_LO) ? (48'(tval_q) * 48'(uses_q[15:0]))
	                              : (48'(tval_q) * 48'(uses_q[31:16]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else begin
			unique case (state_q)
				M_IDLE: if (req.start) state_q <= M_LO;
				M_LO:   state_q <= M_HI;
				M_HI:   state_q <= M_DONE;
				M_DONE: state_q <= M_IDLE;
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && req.start) begin
			uses_q  <= req.uses;
			tval_q  <= req.tval;
			limit_q <= req.limit;
			acc_q   <= '0;
		end else if (state_q == M_LO) begin
			acc_q <= 64'(pp);
		end else if (state_q == M_HI) begin
			acc_q <= acc_q + {pp, 16'd0};
		end
	end

	assign rsp.done = (state_q == M_DONE);
	assign rsp.ge   = (acc_q >= 64'(limit_q));
endmodule
`default_nettype wire

// ===== rtl/weighted_round_robin_unit_picker_unit.sv =====
// Top level: unit table, command sequencer and result register.
// A register command walks the sorted table one entry per cycle to find its place, then
// shifts the tail up one entry per cycle and writes the new entry. A pick walks the
// table per allowed kind: one pass for the slowest time, up to two scan passes and one
// clear pass, plus a multiply-compare in the shared unit for the granted entry; a kind
// with no grant falls through to the next allowed kind, if there is one. Every
// transaction also passes through an accept state and the output stage. The block takes
// no new transaction until the result has been delivered; the result register holds
// while stalled.
`timescale 1ns / 1ps
`default_nettype none
module weighted_round_robin_unit_picker_unit #(
	parameter int MAX_UNITS      = wrr_pkg::MAX_UNITS_DEF,
	parameter int USE_COUNT_BITS = wrr_pkg::USE_COUNT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           command,
	input  wire logic [1:0]                     unit_kind,
	input  wire logic [wrr_pkg::TIME_W-1:0]     job_time,
	input  wire logic [wrr_pkg::MGR_W-1:0]      manager_id,
	input  wire logic [wrr_pkg::SLOT_W-1:0]     unit_slot,
	input  wire logic                           first_kind,
	input  wire logic                           second_kind,
	input  wire logic [1:0]                     kind_count,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [wrr_pkg::STATUS_W-1:0]        status,
	output logic [wrr_pkg::MGR_W-1:0]           granted_manager,
	output logic [wrr_pkg::SLOT_W-1:0]          granted_slot,
	output logic                                granted_kind
);
	localparam int IW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
	localparam int CW = $clog2(MAX_UNITS + 1);
	localparam logic [USE_COUNT_BITS-1:0] USE_MAX = '1;

	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_SHIFT, S_SLOW, S_SCAN, S_MUL, S_CLEAR, S_NEXT, S_OUT
	} state_t;

	// Entry table (flip-flops, one per entry)
	logic [MAX_UNITS-1:0]      valid_q, kind_q, resv_q;
	logic [31:0]               time_q [MAX_UNITS];
	logic [7:0]                mgr_q  [MAX_UNITS];
	logic [3:0]                slot_q [MAX_UNITS];
	logic [USE_COUNT_BITS-1:0] uses_q [MAX_UNITS];
	logic [CW-1:0]             count_q;

	state_t        state_q;
	logic [CW-1:0] idx_q, pos_q;
	logic          kind_sel_q, k1_q, pass_q, tried_q, two_q, any_q;
	logic          ukind_q;
	logic [31:0]   jtime_q, slow_q;
	logic [7:0]    jmgr_q;
	logic [3:0]    jslot_q;
	logic [IW-1:0] g_q;
	logic [USE_COUNT_BITS-1:0] nuse_q;

	wrr_pkg::mul_req_t mreq;
	wrr_pkg::mul_rsp_t mrsp;

	logic [IW-1:0] ix, ixm1;
	logic          match;
	assign ix    = idx_q[IW-1:0];
	assign ixm1  = IW'(idx_q - CW'(1));
	assign match = (idx_q < count_q) && valid_q[ix] && (kind_q[ix] == kind_sel_q);

	assign in_stall = (state_q != S_IDLE);

	// Shared multiply-compare request for the granted entry
	always_comb begin
		mreq.start = (state_q == S_MUL) && !any_q;
		mreq.uses  = 32'(nuse_q);
		mreq.tval  = time_q[g_q];
		mreq.limit = slow_q;
	end

	wrr_mulcmp u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	// Sequencer and table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			resv_q    <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
			any_q     <= 1'b0;
			for (int i = 0; i < MAX_UNITS; i++) uses_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					ukind_q <= unit_kind[0]; jtime_q <= job_time;
					jmgr_q <= manager_id; jslot_q <= unit_slot;
					kind_sel_q <= first_kind; k1_q <= second_kind;
					two_q <= kind_count[1]; idx_q <= '0; slow_q <= '0;
					any_q <= 1'b0; pass_q <= 1'b0; tried_q <= 1'b0;
					if (command == wrr_pkg::CMD_REGISTER) begin
						if (unit_kind[1]) begin
							status <= wrr_pkg::ST_UNSUPPORTED; state_q <= S_OUT;
						end else if (count_q >= CW'(MAX_UNITS)) begin
							status <= wrr_pkg::ST_FULL; state_q <= S_OUT;
						end else state_q <= S_FIND;
					end else if (kind_count == 2'd0) begin
						status <= wrr_pkg::ST_NONE; state_q <= S_OUT;
					end else state_q <= S_SLOW;
					granted_manager <= '0; granted_slot <= '0; granted_kind <= 1'b0;
				end
				S_FIND: begin
					if (idx_q < count_q && time_q[ix] <= jtime_q) idx_q <= idx_q + CW'(1);
					else begin
						pos_q <= idx_q; idx_q <= count_q; state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (idx_q > pos_q) begin
						valid_q[ix] <= valid_q[ixm1]; kind_q[ix] <= kind_q[ixm1];
						time_q[ix] <= time_q[ixm1]; mgr_q[ix] <= mgr_q[ixm1];
						slot_q[ix] <= slot_q[ixm1]; uses_q[ix] <= uses_q[ixm1];
						resv_q[ix] <= resv_q[ixm1];
						idx_q <= idx_q - CW'(1);
					end else begin
						valid_q[ix] <= 1'b1; kind_q[ix] <= ukind_q;
						time_q[ix] <= jtime_q; mgr_q[ix] <= jmgr_q;
						slot_q[ix] <= jslot_q; uses_q[ix] <= '0; resv_q[ix] <= 1'b0;
						count_q <= count_q + CW'(1);
						status <= wrr_pkg::ST_REGISTERED; state_q <= S_OUT;
					end
				end
				S_SLOW: begin
					if (idx_q < count_q) begin
						if (match) begin
							any_q <= 1'b1;
							if (time_q[ix] > slow_q) slow_q <= time_q[ix];
						end
						idx_q <= idx_q + CW'(1);
					end else begin
						idx_q <= '0;
						state_q <= any_q ? S_SCAN : S_NEXT;
					end
				end
				S_SCAN: begin
					if (idx_q < count_q) begin
						if (match && !resv_q[ix]) begin
							g_q <= ix;
							nuse_q <= (uses_q[ix] < USE_MAX) ? uses_q[ix] + 1'b1 : uses_q[ix];
							any_q <= 1'b0;
							state_q <= S_MUL;
						end else idx_q <= idx_q + CW'(1);
					end else if (!pass_q) begin
						idx_q <= '0; state_q <= S_CLEAR;
					end else state_q <= S_NEXT;
				end
				S_CLEAR: begin
					if (idx_q < count_q) begin
						if (match) begin resv_q[ix] <= 1'b0; uses_q[ix] <= '0; end
						idx_q <= idx_q + CW'(1);
					end else begin
						idx_q <= '0; pass_q <= 1'b1; state_q <= S_SCAN;
					end
				end
				S_MUL: begin
					any_q <= 1'b1;
					if (mrsp.done) begin
						uses_q[g_q] <= nuse_q;
						if (time_q[g_q] != 32'd0 && mrsp.ge) resv_q[g_q] <= 1'b1;
						status <= wrr_pkg::ST_GRANTED;
						granted_manager <= mgr_q[g_q]; granted_slot <= slot_q[g_q];
						granted_kind <= kind_q[g_q];
						state_q <= S_OUT;
					end
				end
				S_NEXT: begin
					if (two_q && !tried_q) begin
						tried_q <= 1'b1; kind_sel_q <= k1_q; idx_q <= '0;
						slow_q <= '0; any_q <= 1'b0; pass_q <= 1'b0; state_q <= S_SLOW;
					end else begin
						status <= wrr_pkg::ST_NONE; state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid) out_valid <= 1'b1;
					else if (!out_stall) begin out_valid <= 1'b0; state_q <= S_IDLE; end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_UNITS)) else $error("entry count overflow");
	a_out_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("result outside output state");
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != wrr_pkg::ST_GRANTED |-> granted_manager == '0)
		else $error("nonzero grant fields");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
endmodule
`default_nettype wire
